/* hdl/ipr_pkg.sv */
package ipr_pkg;

    // Fixed field widths of the request and result items
    localparam int PORT_W       = 6;
    localparam int THRESH_W     = 16;
    localparam int PORT_COUNT_W = 16;

    // Configuration channel
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_XOFF_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_XON_THRESHOLD  = 2'd2;

    // Register reset values
    localparam logic                PAUSE_ENABLE_RST = 1'b1;
    localparam logic [THRESH_W-1:0] XOFF_RST         = 16'd1000;
    localparam logic [THRESH_W-1:0] XON_RST          = 16'd5;

    // Event and message codes
    localparam logic ACT_ARRIVAL   = 1'b0;
    localparam logic ACT_DEPARTURE = 1'b1;
    localparam logic MSG_PAUSE     = 1'b0;
    localparam logic MSG_RESUME    = 1'b1;

    typedef struct packed {
        logic              action;
        logic [PORT_W-1:0] port;
        logic              port_known;
        logic              is_pause_frame;
        logic              to_local_agent;
    } event_t;

    typedef struct packed {
        logic                    send_message;
        logic                    message_kind;
        logic [PORT_W-1:0]       message_port;
        logic [PORT_COUNT_W-1:0] port_count;
        logic                    underflow;
    } result_t;

    typedef struct packed {
        logic                pause_enable;
        logic [THRESH_W-1:0] xoff_threshold;
        logic [THRESH_W-1:0] xon_threshold;
    } cfg_t;

endpackage

/* hdl/ipr_event_if.sv */
interface ipr_event_if
    import ipr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              action;
    logic [PORT_W-1:0] port;
    logic              port_known;
    logic              is_pause_frame;
    logic              to_local_agent;

    modport source (output valid, action, port, port_known, is_pause_frame, to_local_agent,
                    input ready);
    modport sink   (input valid, action, port, port_known, is_pause_frame, to_local_agent,
                    output ready);
endinterface

/* hdl/ipr_result_if.sv */
interface ipr_result_if
    import ipr_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    send_message;
    logic                    message_kind;
    logic [PORT_W-1:0]       message_port;
    logic [PORT_COUNT_W-1:0] port_count;
    logic                    underflow;

    modport source (output valid, send_message, message_kind, message_port, port_count,
                    underflow, input ready);
    modport sink   (input valid, send_message, message_kind, message_port, port_count,
                    underflow, output ready);
endinterface

/* hdl/ipr_cfg_if.sv */
interface ipr_cfg_if
    import ipr_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/ipr_ram.sv */
module ipr_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

/* hdl/ipr_update.sv */
module ipr_update
    import ipr_pkg::*;
#(
    parameter int NUM_PORTS   = 64,
    parameter int COUNT_WIDTH = 16
) (
    input  event_t                 ev,
    input  cfg_t                   cfg,
    input  logic [COUNT_WIDTH-1:0] cur_count,
    input  logic                   cur_paused,
    output logic                   wen,
    output logic [COUNT_WIDTH-1:0] new_count,
    output logic                   new_paused,
    output result_t                res
);
    localparam int CMP_W = (COUNT_WIDTH > THRESH_W) ? COUNT_WIDTH : THRESH_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic             in_range;
    logic             acct;

    assign in_range = (32'(ev.port) < NUM_PORTS);
    assign acct     = in_range && cfg.pause_enable && ev.port_known && !ev.is_pause_frame;

    // Count step, threshold checks and message generation
    always_comb
    begin
        wen              = 1'b0;
        new_count        = cur_count;
        new_paused       = cur_paused;
        res.send_message = 1'b0;
        res.message_kind = MSG_PAUSE;
        res.message_port = '0;
        res.underflow    = 1'b0;
        if (ev.action == ACT_ARRIVAL)
        begin
            if (acct && !ev.to_local_agent)
            begin
                wen = 1'b1;
                if (cur_count != COUNT_MAX)
                begin
                    new_count = cur_count + COUNT_WIDTH'(1);
                end
                if (CMP_W'(new_count) > CMP_W'(cfg.xoff_threshold) && !cur_paused)
                begin
                    res.send_message = 1'b1;
                    res.message_kind = MSG_PAUSE;
                    res.message_port = ev.port;
                    new_paused       = 1'b1;
                end
            end
        end
        else
        begin
            if (acct)
            begin
                wen = 1'b1;
                if (cur_count == '0)
                begin
                    res.underflow = 1'b1;
                end
                else
                begin
                    new_count = cur_count - COUNT_WIDTH'(1);
                end
                if (CMP_W'(new_count) < CMP_W'(cfg.xon_threshold) && cur_paused)
                begin
                    res.send_message = 1'b1;
                    res.message_kind = MSG_RESUME;
                    res.message_port = ev.port;
                    new_paused       = 1'b0;
                end
            end
        end
        res.port_count = in_range ? PORT_COUNT_W'(new_count) : '0;
    end
endmodule

/* hdl/ingress_pause_resume_tracker_top.sv */
// Per-port pause/resume tracker. Each request (arrival or departure on an
// input port) is accepted in ST_IDLE and its port's entry {paused, count} is
// read from a single-port-read memory into its registered read output; in
// ST_CALC the entry is updated, written back and the result is loaded into the
// output register, after which the block returns to ST_IDLE. A new request is
// not accepted until the previous one has left ST_CALC.
// A result waiting on the output and not yet taken stalls the update step.
// After reset the memory is cleared one entry per cycle, during which no
// request is accepted; configuration writes are taken at any time.
module ingress_pause_resume_tracker_top
    import ipr_pkg::*;
#(
    parameter int NUM_PORTS   = 64,
    parameter int COUNT_WIDTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    ipr_cfg_if.sink      cfg,
    ipr_event_if.sink    ingress,
    ipr_result_if.source result
);
    localparam int AW    = $clog2(NUM_PORTS);
    localparam int MEM_W = COUNT_WIDTH + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_PORTS - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC
    } state_t;

    state_t  state_reg, state_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    cfg_t    cfg_reg, cfg_next;
    event_t  ev_reg;
    result_t res_reg, res_next;
    logic    out_valid_reg, out_valid_next;

    logic                   accept;
    logic                   proceed;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [MEM_W-1:0]       mem_wdata;
    logic [MEM_W-1:0]       mem_rdata;
    logic                   upd_wen;
    logic [COUNT_WIDTH-1:0] upd_count;
    logic                   upd_paused;
    result_t                upd_res;
    event_t                 ev_in;

    assign ev_in.action         = ingress.action;
    assign ev_in.port           = ingress.port;
    assign ev_in.port_known     = ingress.port_known;
    assign ev_in.is_pause_frame = ingress.is_pause_frame;
    assign ev_in.to_local_agent = ingress.to_local_agent;

    assign ingress.ready = (state_reg == ST_IDLE);
    assign accept        = ingress.valid && ingress.ready;
    assign proceed       = (state_reg == ST_CALC) && (!out_valid_reg || result.ready);

    // Configuration writes; unknown indexes are dropped
    assign cfg.ready = 1'b1;
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_PAUSE_ENABLE:   cfg_next.pause_enable   = cfg.data[0];
                CFG_XOFF_THRESHOLD: cfg_next.xoff_threshold = THRESH_W'(cfg.data);
                CFG_XON_THRESHOLD:  cfg_next.xon_threshold  = THRESH_W'(cfg.data);
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pause_enable   <= PAUSE_ENABLE_RST;
            cfg_reg.xoff_threshold <= XOFF_RST;
            cfg_reg.xon_threshold  <= XON_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Hold the accepted request for the update step
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ev_reg <= ev_in;
        end
    end

    ipr_ram #(
        .WIDTH (MEM_W),
        .DEPTH (NUM_PORTS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (accept),
        .raddr (AW'(ingress.port)),
        .rdata (mem_rdata)
    );

    ipr_update #(
        .NUM_PORTS   (NUM_PORTS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_update (
        .ev         (ev_reg),
        .cfg        (cfg_reg),
        .cur_count  (mem_rdata[COUNT_WIDTH-1:0]),
        .cur_paused (mem_rdata[COUNT_WIDTH]),
        .wen        (upd_wen),
        .new_count  (upd_count),
        .new_paused (upd_paused),
        .res        (upd_res)
    );

    // Memory write: clearing pass, then write-back of updated entries
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = proceed && upd_wen;
            mem_waddr = AW'(ev_reg.port);
            mem_wdata = {upd_paused, upd_count};
        end
    end

    // Sequencer next state and output register
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (proceed)
                begin
                    res_next       = upd_res;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.send_message = res_reg.send_message;
    assign result.message_kind = res_reg.message_kind;
    assign result.message_port = res_reg.message_port;
    assign result.port_count   = res_reg.port_count;
    assign result.underflow    = res_reg.underflow;
endmodule
